// ===== sv/tifi_pkg.sv =====
// Package for the timed input fault injector.
// Holds field widths, status and command codes, and the state and result types.
// No dependencies; every other file of the block imports it.
`default_nettype none

package tifi_pkg;

  // Width of the wrapping time base that elapsed time is taken modulo.
  localparam int unsigned TIME_WIDTH = 32;
  localparam int unsigned CMP_W      = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

  localparam int unsigned IN_BITS   = 132;
  localparam int unsigned IN_BYTES  = (IN_BITS + 7) / 8;
  localparam int unsigned OUT_BITS  = 167;
  localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8;

  // Configuration register indexes.
  localparam logic [1:0] REG_MIN_DUR = 2'd0;
  localparam logic [1:0] REG_MAX_DUR = 2'd1;
  localparam logic [1:0] REG_MAGIC   = 2'd2;

  // Mailbox commands. The two reserved codes are always refused.
  localparam logic [1:0] CMD_INJECT = 2'd0;
  localparam logic [1:0] CMD_ABORT  = 2'd1;
  localparam logic [1:0] CMD_RSVD2  = 2'd2;
  localparam logic [1:0] CMD_RSVD3  = 2'd3;

  // Status codes.
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_ACTIVE   = 3'd1;
  localparam logic [2:0] ST_COMPLETE = 3'd2;
  localparam logic [2:0] ST_ABORTED  = 3'd3;
  localparam logic [2:0] ST_REJECTED = 3'd4;

  // Completion reasons.
  localparam logic [1:0] RSN_NONE    = 2'd0;
  localparam logic [1:0] RSN_TIMEOUT = 2'd1;
  localparam logic [1:0] RSN_ABORT   = 2'd2;

  typedef struct packed {
    logic [31:0] min_dur;
    logic [31:0] max_dur;
    logic [31:0] magic_key;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        nat_vld;
    logic [31:0] req_seq;
    logic [1:0]  command_code;
    logic [31:0] duration_ms;
    logic        magic_write;
    logic [31:0] magic_value;
  } item_t;

  typedef struct packed {
    logic        injecting;
    logic [31:0] start_time;
    logic [31:0] remaining;
    logic [2:0]  status;
    logic [1:0]  reason;
    logic [31:0] applied_seq;
    logic [31:0] magic_reg;
    logic [31:0] accepted;
    logic [31:0] rejected;
    logic [31:0] injected;
    logic [31:0] nat_invalid;
  } state_t;

  typedef struct packed {
    logic        out_valid;
    logic [2:0]  out_status;
    logic [1:0]  out_reason;
    logic [31:0] out_remaining_ms;
    logic        out_active;
    logic [31:0] out_accepted;
    logic [31:0] out_rejected;
    logic [31:0] out_injected;
    logic [31:0] out_natural_invalid;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/tifi_cfg.sv =====
// Configuration register file of the fault injector: duration limits and magic key.
// Depends on tifi_pkg.
`default_nettype none

module tifi_cfg
  import tifi_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        we_i,
  input  wire logic [1:0]  addr_i,
  input  wire logic [31:0] data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (addr_i)
        REG_MIN_DUR: cfg_d.min_dur   = data_i;
        REG_MAX_DUR: cfg_d.max_dur   = data_i;
        REG_MAGIC:   cfg_d.magic_key = data_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_dur   <= 32'd1;
      cfg_q.max_dur   <= 32'd60000;
      cfg_q.magic_key <= 32'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== sv/tifi_step.sv =====
// Single-pass update of the injector for one sample tick: request check,
// window timing and counters. Purely combinational; depends on tifi_pkg.
`default_nettype none

module tifi_step
  import tifi_pkg::*;
(
  input  wire cfg_t   cfg_i,
  input  wire item_t  item_i,
  input  wire state_t state_i,
  output state_t      state_o,
  output result_t     result_o
);

  logic [31:0]        magic;
  logic               new_req;
  logic               refuse;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [CMP_W-1:0]   elapsed_w;
  logic [CMP_W-1:0]   dur_w;
  logic               valid;
  state_t             s;

  always_comb begin
    s       = state_i;
    magic   = item_i.magic_write ? item_i.magic_value : state_i.magic_reg;
    new_req = (item_i.req_seq != state_i.applied_seq);
    refuse  = 1'b0;

    if (new_req) begin
      if (item_i.req_seq == 32'd0 || magic != cfg_i.magic_key) begin
        refuse = 1'b1;
      end else if (item_i.command_code == CMD_INJECT) begin
        if (state_i.injecting || item_i.duration_ms < cfg_i.min_dur ||
            item_i.duration_ms > cfg_i.max_dur) begin
          refuse = 1'b1;
        end else begin
          s.injecting  = 1'b1;
          s.start_time = item_i.now_ms;
          s.remaining  = item_i.duration_ms;
          s.reason     = RSN_NONE;
          s.status     = ST_ACTIVE;
          s.accepted   = state_i.accepted + 32'd1;
        end
      end else if (item_i.command_code == CMD_ABORT) begin
        s.accepted  = state_i.accepted + 32'd1;
        s.injecting = 1'b0;
        s.remaining = 32'd0;
        s.status    = ST_ABORTED;
        s.reason    = RSN_ABORT;
      end else begin
        refuse = 1'b1;
      end

      if (refuse) begin
        s.rejected  = state_i.rejected + 32'd1;
        s.injecting = 1'b0;
        s.remaining = 32'd0;
        s.status    = ST_REJECTED;
        s.reason    = RSN_NONE;
      end
      s.applied_seq = item_i.req_seq;
      s.magic_reg   = 32'd0;
    end else begin
      s.magic_reg = magic;
    end

    // Elapsed time wraps at the time base width.
    elapsed   = TIME_WIDTH'(CMP_W'(item_i.now_ms) - CMP_W'(s.start_time));
    elapsed_w = CMP_W'(elapsed);
    dur_w     = CMP_W'(item_i.duration_ms);

    if (s.injecting) begin
      if (elapsed_w >= dur_w) begin
        s.injecting = 1'b0;
        s.remaining = 32'd0;
        s.status    = ST_COMPLETE;
        s.reason    = RSN_TIMEOUT;
      end else begin
        s.remaining = 32'(dur_w - elapsed_w);
      end
    end

    if (!item_i.nat_vld) begin
      s.nat_invalid = state_i.nat_invalid + 32'd1;
    end
    if (s.injecting) begin
      s.injected = state_i.injected + 32'd1;
      valid      = 1'b0;
    end else begin
      valid      = item_i.nat_vld;
    end
  end

  assign state_o = s;

  assign result_o.out_valid           = valid;
  assign result_o.out_status          = s.status;
  assign result_o.out_reason          = s.reason;
  assign result_o.out_remaining_ms    = s.remaining;
  assign result_o.out_active          = s.injecting;
  assign result_o.out_accepted        = s.accepted;
  assign result_o.out_rejected        = s.rejected;
  assign result_o.out_injected        = s.injected;
  assign result_o.out_natural_invalid = s.nat_invalid;

endmodule

`default_nettype wire

// ===== sv/timed_input_fault_injector_core.sv =====
// Top level of the timed input fault injector.
// Depends on tifi_pkg, tifi_cfg and tifi_step.
//
// Usage: every beat on the slave stream is one sample tick carrying the time, the
// natural validity of the watched input and a snapshot of the host mailbox
// (request sequence, command, duration, magic word). For every input beat exactly
// one result beat leaves on the master stream: the validity after injection, the
// status and completion reason, the time left in the window and four wrapping
// event counters.
// The beat is first captured in an input register; when it moves on, the tick's
// update is done in a single pass and written to the result register together with
// the new block state. A result beat is therefore presented on the master side from the
// result register, having passed through the input register first, and one beat per
// cycle is sustained while the receiver keeps m_axis_tready high.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more beat; after that s_axis_tready drops until the
// master side drains. No beat is lost or duplicated.
// Reset clears the block state: no window, status idle, reason none, all counters
// and last applied sequence zero; duration limits, magic key go to 1, 60000, 1.
// The user writes configuration through the cfg port only while idle, unenforced.
`default_nettype none

module timed_input_fault_injector_core
  import tifi_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,

  // Fields from bit 0 up: now_ms[31:0], nat_vld[32], req_seq[64:33],
  // command_code[66:65], duration_ms[98:67], magic_write[99], magic_value[131:100].
  input  wire logic [IN_BYTES*8-1:0]    s_axis_tdata,
  input  wire logic                     s_axis_tvalid,
  output      logic                     s_axis_tready,

  // Fields from bit 0 up: out_valid[0], out_status[3:1], out_reason[5:4],
  // out_remaining_ms[37:6], out_active[38], out_accepted[70:39],
  // out_rejected[102:71], out_injected[134:103], out_natural_invalid[166:135].
  output      logic [OUT_BYTES*8-1:0]   m_axis_tdata,
  output      logic                     m_axis_tvalid,
  input  wire logic                     m_axis_tready,

  input  wire logic                     cfg_we_i,
  input  wire logic [1:0]               cfg_addr_i,
  input  wire logic [31:0]              cfg_data_i
);

  cfg_t    cfg;
  item_t   in_item;
  item_t   item_q;
  logic    item_vld_q;
  state_t  state_q, state_d;
  result_t res_d, res_q;
  logic    out_vld_q;
  logic    advance;

  tifi_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .addr_i (cfg_addr_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // Unpack the input beat, lowest field first.
  assign in_item.now_ms       = s_axis_tdata[31:0];
  assign in_item.nat_vld      = s_axis_tdata[32];
  assign in_item.req_seq      = s_axis_tdata[64:33];
  assign in_item.command_code = s_axis_tdata[66:65];
  assign in_item.duration_ms  = s_axis_tdata[98:67];
  assign in_item.magic_write  = s_axis_tdata[99];
  assign in_item.magic_value  = s_axis_tdata[131:100];

  // The captured beat moves into the result register when that slot is free or
  // being drained this cycle.
  assign advance       = item_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !item_vld_q || advance;

  tifi_step u_step (
    .cfg_i    (cfg),
    .item_i   (item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      state_q    <= '0;
    end else begin
      if (s_axis_tready) begin
        item_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= in_item;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0,
                          res_q.out_natural_invalid,
                          res_q.out_injected,
                          res_q.out_rejected,
                          res_q.out_accepted,
                          res_q.out_active,
                          res_q.out_remaining_ms,
                          res_q.out_reason,
                          res_q.out_status,
                          res_q.out_valid};

endmodule

`default_nettype wire
